@@ hdl/ccc_pkg.sv @@
`timescale 1ns / 1ps

package ccc_pkg;

   // bit-serial root and quotient lengths
   localparam int ROOT_STEPS  = 32;
   localparam int QUO_BITS    = 17;
   localparam int DIV_STAGES  = QUO_BITS + 1;
   localparam int QUEUE_DEPTH = 4;

   // stream widths
   localparam int REQ_DATA_W = 192;
   localparam int RSP_DATA_W = 64;

   // normal limits in Q1.15
   localparam logic [16:0] NORM_NEG_MAX = 17'd32768;
   localparam logic [16:0] NORM_POS_MAX = 17'd32767;

   // centre difference split into sign and magnitude
   typedef struct packed {
      logic        far;
      logic [31:0] rsum;
      logic        sx;
      logic [31:0] mx;
      logic        sy;
      logic [31:0] my;
   } ccc_diff_type;

   // squared components
   typedef struct packed {
      ccc_diff_type d;
      logic [63:0]  sqx;
      logic [63:0]  sqy;
   } ccc_sqr_type;

   // classified item handed from front to back
   typedef struct packed {
      ccc_diff_type d;
      logic [63:0]  sq;
   } ccc_work_type;

   // square root iteration state
   typedef struct packed {
      ccc_diff_type d;
      logic [63:0]  sq;
      logic [33:0]  rem;
      logic [31:0]  root;
   } ccc_root_type;

   // normal division iteration state
   typedef struct packed {
      logic        hit;
      logic [31:0] pen;
      logic [31:0] len;
      logic        sx;
      logic        sy;
      logic [31:0] rx;
      logic [31:0] ry;
      logic [16:0] nx;
      logic [16:0] ny;
      logic [16:0] qx;
      logic [16:0] qy;
   } ccc_div_type;

endpackage

@@ hdl/ccc_front.sv @@
`timescale 1ns / 1ps

module ccc_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  logic [ccc_pkg::REQ_DATA_W-1:0]   in_data,
   output logic                             push,
   output ccc_pkg::ccc_work_type            push_data,
   input  logic                             full
);

   logic                  en;
   logic [32:0]           dx, dy, adx, ady;
   ccc_pkg::ccc_diff_type diff_in;
   ccc_pkg::ccc_diff_type diff_ff;
   ccc_pkg::ccc_sqr_type  sqr_in;
   ccc_pkg::ccc_sqr_type  sqr_ff;
   ccc_pkg::ccc_work_type work_in;
   ccc_pkg::ccc_work_type work_ff;
   logic [64:0]           sum;
   logic [2:0]            vld_ff;

   // whole front advances together unless its last item is held by a full queue
   assign en       = !vld_ff[2] || !full;
   assign in_ready = en;
   assign push     = vld_ff[2] && !full;
   assign push_data = work_ff;

   // centre differences, magnitudes and radius sum
   always_comb begin
      dx  = {in_data[31], in_data[31:0]} - {in_data[126], in_data[126:95]};
      dy  = {in_data[63], in_data[63:32]} - {in_data[158], in_data[158:127]};
      adx = dx[32] ? 33'(-dx) : dx;
      ady = dy[32] ? 33'(-dy) : dy;
      diff_in.far  = adx[32] | ady[32];
      diff_in.rsum = {1'b0, in_data[94:64]} + {1'b0, in_data[189:159]};
      diff_in.sx   = dx[32];
      diff_in.mx   = adx[31:0];
      diff_in.sy   = dy[32];
      diff_in.my   = ady[31:0];
   end

   // squares
   always_comb begin
      sqr_in.d   = diff_ff;
      sqr_in.sqx = 64'(diff_ff.mx) * 64'(diff_ff.mx);
      sqr_in.sqy = 64'(diff_ff.my) * 64'(diff_ff.my);
   end

   // squared length, overflow marks far centres
   always_comb begin
      sum           = {1'b0, sqr_ff.sqx} + {1'b0, sqr_ff.sqy};
      work_in.d     = sqr_ff.d;
      work_in.d.far = sqr_ff.d.far | sum[64];
      work_in.sq    = sum[63:0];
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[1:0], in_valid};
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (en) begin
         diff_ff <= diff_in;
         sqr_ff  <= sqr_in;
         work_ff <= work_in;
      end
   end

endmodule

@@ hdl/ccc_queue.sv @@
`timescale 1ns / 1ps

module ccc_queue #(
   parameter int DEPTH = ccc_pkg::QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  ccc_pkg::ccc_work_type push_data,
   output logic                  full,
   input  logic                  pop,
   output logic                  head_valid,
   output ccc_pkg::ccc_work_type head_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   ccc_pkg::ccc_work_type slot_ff [DEPTH];
   logic [PW-1:0]         wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic                  do_pop;

   assign full       = (cnt_ff == CW'(DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_data  = slot_ff[rd_ff];
   assign do_pop     = pop && head_valid;

   // pointer and fill count update
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == PW'(DEPTH - 1)) ? '0 : PW'(wr_ff + 1'b1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == PW'(DEPTH - 1)) ? '0 : PW'(rd_ff + 1'b1);
      end
      if (push && !do_pop) begin
         cnt_in = CW'(cnt_ff + 1'b1);
      end else if (!push && do_pop) begin
         cnt_in = CW'(cnt_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

endmodule

@@ hdl/ccc_back.sv @@
`timescale 1ns / 1ps

module ccc_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             head_valid,
   input  ccc_pkg::ccc_work_type            head_data,
   output logic                             pop,
   output logic                             out_valid,
   input  logic                             out_ready,
   output logic                             out_hit,
   output logic [ccc_pkg::RSP_DATA_W-1:0]   out_data
);

   localparam int RS = ccc_pkg::ROOT_STEPS;
   localparam int DS = ccc_pkg::DIV_STAGES;

   // one bit of the integer square root
   function automatic ccc_pkg::ccc_root_type root_step(input ccc_pkg::ccc_root_type a);
      ccc_pkg::ccc_root_type r;
      logic [35:0]           t;
      logic [35:0]           trial;
      r     = a;
      t     = {a.rem, a.sq[63:62]};
      trial = {2'b00, a.root, 2'b01};
      if (t >= trial) begin
         r.rem  = 34'(t - trial);
         r.root = {a.root[30:0], 1'b1};
      end else begin
         r.rem  = t[33:0];
         r.root = {a.root[30:0], 1'b0};
      end
      r.sq = {a.sq[61:0], 2'b00};
      return r;
   endfunction

   // one quotient bit for each component
   function automatic ccc_pkg::ccc_div_type div_step(input ccc_pkg::ccc_div_type a);
      ccc_pkg::ccc_div_type r;
      logic [32:0]          tx;
      logic [32:0]          ty;
      r  = a;
      tx = {a.rx, a.nx[16]};
      ty = {a.ry, a.ny[16]};
      if (tx >= {1'b0, a.len}) begin
         r.rx = 32'(tx - {1'b0, a.len});
         r.qx = {a.qx[15:0], 1'b1};
      end else begin
         r.rx = tx[31:0];
         r.qx = {a.qx[15:0], 1'b0};
      end
      if (ty >= {1'b0, a.len}) begin
         r.ry = 32'(ty - {1'b0, a.len});
         r.qy = {a.qy[15:0], 1'b1};
      end else begin
         r.ry = ty[31:0];
         r.qy = {a.qy[15:0], 1'b0};
      end
      r.nx = {a.nx[15:0], 1'b0};
      r.ny = {a.ny[15:0], 1'b0};
      return r;
   endfunction

   // rounded quotient to signed saturated Q1.15
   function automatic logic [15:0] fmt(input logic [16:0] q, input logic neg);
      logic [16:0] qs;
      if (neg) begin
         qs = (q > ccc_pkg::NORM_NEG_MAX) ? ccc_pkg::NORM_NEG_MAX : q;
         return 16'(17'd0 - qs);
      end
      qs = (q > ccc_pkg::NORM_POS_MAX) ? ccc_pkg::NORM_POS_MAX : q;
      return qs[15:0];
   endfunction

   logic                  en;
   ccc_pkg::ccc_root_type seed;
   ccc_pkg::ccc_root_type root_ff [RS];
   logic [RS-1:0]         root_vld_ff;
   ccc_pkg::ccc_root_type last;
   ccc_pkg::ccc_div_type  div_init;
   ccc_pkg::ccc_div_type  div_ff [DS];
   logic [DS-1:0]         div_vld_ff;
   ccc_pkg::ccc_div_type  fin;
   logic [47:0]           num_x, num_y;
   logic                  out_vld_ff;
   logic                  out_hit_ff, out_hit_in;
   logic [ccc_pkg::RSP_DATA_W-1:0] out_data_ff, out_data_in;

   // the back pipeline moves as one while the output register can take a result
   assign en        = !out_vld_ff || out_ready;
   assign pop       = en && head_valid;
   assign out_valid = out_vld_ff;
   assign out_hit   = out_hit_ff;
   assign out_data  = out_data_ff;

   always_comb begin
      seed.d    = head_data.d;
      seed.sq   = head_data.sq;
      seed.rem  = '0;
      seed.root = '0;
   end

   // contact test and division set-up
   always_comb begin
      last            = root_ff[RS-1];
      num_x           = {1'b0, last.d.mx, 15'd0} + {17'd0, last.root[31:1]};
      num_y           = {1'b0, last.d.my, 15'd0} + {17'd0, last.root[31:1]};
      div_init.hit    = !last.d.far && (last.root < last.d.rsum);
      div_init.pen    = 32'(last.d.rsum - last.root);
      div_init.len    = last.root;
      div_init.sx     = last.d.sx;
      div_init.sy     = last.d.sy;
      div_init.rx     = {1'b0, num_x[47:17]};
      div_init.ry     = {1'b0, num_y[47:17]};
      div_init.nx     = num_x[16:0];
      div_init.ny     = num_y[16:0];
      div_init.qx     = '0;
      div_init.qy     = '0;
   end

   // result formatting
   always_comb begin
      fin         = div_ff[DS-1];
      out_hit_in  = fin.hit;
      out_data_in = '0;
      if (fin.hit) begin
         out_data_in[63:32] = fin.pen;
         if (fin.len != '0) begin
            out_data_in[15:0]  = fmt(fin.qx, fin.sx);
            out_data_in[31:16] = fmt(fin.qy, fin.sy);
         end
      end
   end

   // stage valids
   always_ff @(posedge clock) begin
      if (reset) begin
         root_vld_ff <= '0;
         div_vld_ff  <= '0;
         out_vld_ff  <= 1'b0;
      end else if (en) begin
         root_vld_ff <= {root_vld_ff[RS-2:0], head_valid};
         div_vld_ff  <= {div_vld_ff[DS-2:0], root_vld_ff[RS-1]};
         out_vld_ff  <= div_vld_ff[DS-1];
      end
   end

   // stage payloads
   always_ff @(posedge clock) begin
      if (en) begin
         root_ff[0] <= root_step(seed);
         for (int i = 1; i < RS; i++) begin
            root_ff[i] <= root_step(root_ff[i-1]);
         end
         div_ff[0] <= div_init;
         for (int i = 1; i < DS; i++) begin
            div_ff[i] <= div_step(div_ff[i-1]);
         end
         out_hit_ff  <= out_hit_in;
         out_data_ff <= out_data_in;
      end
   end

endmodule

@@ hdl/circle_circle_contact.sv @@
`timescale 1ns / 1ps

// Circle pair contact test.
// req channel: one circle pair per transfer; rsp channel: one contact result
// per pair, in the order the pairs were accepted.
// The front computes centre differences, squares and the squared length and
// marks far pairs; a small queue decouples it from the back, which takes a
// bit-serial pipelined square root (32 stages, one root bit each), the
// contact test, and two pipelined restoring dividers (17 quotient bits, one
// per stage) for the normal.
// Throughput: one pair per cycle while rsp_tready stays high, set by the fully pipelined root and dividers.
// When rsp_tready is low while a result is waiting, the back pipeline holds; the queue then fills and
// req_tready falls once the front's last stage is held.
// Reset clears all valids and queue pointers; no result is pending after it.
module circle_circle_contact #(
   parameter int QUEUE_DEPTH = ccc_pkg::QUEUE_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // center_a_x[31:0], center_a_y[63:32], radius_a[94:64], center_b_x[126:95],
   // center_b_y[158:127], radius_b[189:159], zero fill
   input  logic [ccc_pkg::REQ_DATA_W-1:0]    req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // normal_x[15:0], normal_y[31:16], penetration[63:32]
   output logic [ccc_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // hit[0]
   output logic                              rsp_tuser
);

   logic                  push, full, pop, head_valid;
   ccc_pkg::ccc_work_type push_data, head_data;

   ccc_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req_tdata),
      .push      (push),
      .push_data (push_data),
      .full      (full)
   );

   ccc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   ccc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_data  (head_data),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_hit    (rsp_tuser),
      .out_data   (rsp_tdata)
   );

endmodule

@@ verif/circle_circle_contact_tb.sv @@
`timescale 1ns / 1ps

module circle_circle_contact_tb;

   typedef struct packed {
      logic [31:0] ax;
      logic [31:0] ay;
      logic [30:0] ra;
      logic [31:0] bx;
      logic [31:0] by;
      logic [30:0] rb;
   } pair_type;

   typedef struct packed {
      logic        hit;
      logic [15:0] nx;
      logic [15:0] ny;
      logic [31:0] pen;
   } contact_type;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 120;

   logic                           clock;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [ccc_pkg::REQ_DATA_W-1:0] req_tdata;
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic [ccc_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           rsp_tuser;

   pair_type    pending_pairs[$];
   contact_type expected_contacts[$];
   int          errors;
   int          send_idle_pct;
   int          recv_idle_pct;
   bit          recv_hold;
   int          quiet_cycles;

   circle_circle_contact u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   initial clock = 1'b0;
   always #6 clock = ~clock;

   // exact floor square root of a 64-bit value
   function automatic logic [63:0] floor_root(logic [63:0] v);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // one Q1.15 component of d / len, rounded half away, saturated
   function automatic logic [15:0] normal_part(logic signed [33:0] d, logic [63:0] len);
      logic [63:0] mag;
      logic [63:0] q;
      mag = (d < 0) ? 64'(-d) : 64'(d);
      q = ((mag << 15) + (len >> 1)) / len;
      if (d < 0) begin
         if (q > 32768) q = 32768;
         return 16'(17'h10000 - 17'(q));
      end
      if (q > 32767) q = 32767;
      return q[15:0];
   endfunction

   function automatic contact_type predict_contact(pair_type p);
      logic signed [33:0] dx;
      logic signed [33:0] dy;
      logic [63:0]        adx;
      logic [63:0]        ady;
      logic [63:0]        sx;
      logic [63:0]        s;
      logic [63:0]        rsum;
      logic [63:0]        len;
      bit                 far;
      contact_type        c;
      dx = 34'(signed'(p.ax)) - 34'(signed'(p.bx));
      dy = 34'(signed'(p.ay)) - 34'(signed'(p.by));
      adx = (dx < 0) ? 64'(-dx) : 64'(dx);
      ady = (dy < 0) ? 64'(-dy) : 64'(dy);
      rsum = 64'(p.ra) + 64'(p.rb);
      c = '0;
      far = 0;
      len = 0;
      if (adx > 64'hFFFF_FFFF || ady > 64'hFFFF_FFFF) begin
         far = 1;
      end else begin
         sx = adx * adx;
         s = sx + ady * ady;
         if (s < sx) far = 1;
         else len = floor_root(s);
      end
      if (far || len >= rsum) return c;
      c.hit = 1;
      c.pen = 32'(rsum - len);
      if (len != 0) begin
         c.nx = normal_part(dx, len);
         c.ny = normal_part(dy, len);
      end
      return c;
   endfunction

   // random field value weighted towards extremes and small values
   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 5))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return $urandom_range(0, 1 << 20) - (1 << 19);
         default: return $urandom;
      endcase
   endfunction

   function automatic pair_type random_pair();
      pair_type p;
      p.ax = pick_word();
      p.ay = pick_word();
      p.ra = 31'(pick_word());
      if ($urandom_range(0, 3) != 0) begin
         // near pair so that many collide
         p.bx = p.ax + ($urandom_range(0, 1 << 22) - (1 << 21));
         p.by = p.ay + ($urandom_range(0, 1 << 22) - (1 << 21));
         p.ra = 31'($urandom_range(0, 1 << 22));
         p.rb = 31'($urandom_range(0, 1 << 22));
      end else begin
         p.bx = pick_word();
         p.by = pick_word();
         p.rb = 31'(pick_word());
      end
      return p;
   endfunction

   // pair driver
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= '0;
      end else if (!req_tvalid || req_tready) begin
         if (pending_pairs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            pair_type p;
            p = pending_pairs.pop_front();
            expected_contacts.push_back(predict_contact(p));
            req_tvalid <= 1'b1;
            req_tdata  <= ccc_pkg::REQ_DATA_W'({p.rb, p.by, p.bx, p.ra, p.ay, p.ax});
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result monitor and ready generation
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            contact_type got;
            contact_type exp_c;
            got = {rsp_tuser, rsp_tdata[15:0], rsp_tdata[31:16], rsp_tdata[63:32]};
            if (expected_contacts.size() == 0) begin
               $display("%0t: unexpected result %h", $time, got);
               errors++;
            end else begin
               exp_c = expected_contacts.pop_front();
               if (got !== exp_c)
                  $display({"%0t: mismatch expected hit %b nx %h ny %h pen %h,",
                            " got hit %b nx %h ny %h pen %h"},
                     $time, exp_c.hit, exp_c.nx, exp_c.ny, exp_c.pen,
                     got.hit, got.nx, got.ny, got.pen);
               if (got !== exp_c) errors++;
            end
         end
         rsp_tready <= !recv_hold && ($urandom_range(0, 99) >= recv_idle_pct);
      end
   end

   // watchdog on transfers
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || recv_hold)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("circle_circle_contact_tb failed");
         $finish;
      end
   end

   task automatic wait_drained();
      while (pending_pairs.size() != 0 || req_tvalid || expected_contacts.size() != 0)
         @(posedge clock);
   endtask

   task automatic add_pair(logic [31:0] ax, logic [31:0] ay, logic [30:0] ra,
                           logic [31:0] bx, logic [31:0] by, logic [30:0] rb);
      pending_pairs.push_back('{ax, ay, ra, bx, by, rb});
   endtask

   initial begin
      send_idle_pct = 14;
      recv_idle_pct = 53;
      recv_hold = 0;
      reset = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: coincident centres, zero radii, axis normals, far pairs, limits
      add_pair(0, 0, 31'h10000, 0, 0, 31'h10000);
      add_pair(0, 0, 0, 0, 0, 0);
      add_pair(32'h10000, 0, 31'h10000, 0, 0, 31'h10000);
      add_pair(32'h10000, 0, 31'h8000, 0, 0, 31'h8000);
      add_pair(0, 32'hFFFF0000, 31'h20000, 0, 0, 31'h0);
      add_pair(32'h7FFFFFFF, 32'h7FFFFFFF, 31'h7FFFFFFF,
               32'h80000000, 32'h80000000, 31'h7FFFFFFF);
      add_pair(32'h7FFFFFFF, 0, 31'h7FFFFFFF, 32'h80000000, 0, 31'h7FFFFFFF);
      add_pair(32'h80000000, 32'h80000000, 31'h7FFFFFFF,
               32'h80000000, 32'h80000000, 31'h7FFFFFFF);
      add_pair(32'h7FFFFFFF, 32'h7FFFFFFF, 31'h7FFFFFFF, 0, 0, 31'h7FFFFFFF);
      add_pair(1, 0, 1, 0, 0, 1);
      add_pair(1, 1, 31'h2, 0, 0, 31'h0);
      add_pair(32'hFFFFFFFF, 32'hFFFFFFFF, 31'h7FFFFFFF, 0, 0, 0);
      add_pair(3, 4, 31'h6, 0, 0, 0);
      add_pair(3, 4, 31'h5, 0, 0, 0);
      add_pair(32'h30000, 32'h40000, 31'h50001, 0, 0, 0);
      add_pair(32'hFFFFFFFF, 32'hFFFFFFFF, 31'h7FFFFFFF,
               32'hFFFFFFFF, 32'hFFFFFFFF, 31'h7FFFFFFF);
      add_pair(32'h5555AAAA, 32'hAAAA5555, 31'h2AAAD555,
               32'h5555AAAA, 32'hAAAA5554, 31'h55552AAA);
      wait_drained();

      // random, first idling mix
      repeat (350) pending_pairs.push_back(random_pair());
      wait_drained();

      // long receiver hold while pairs keep coming
      send_idle_pct = 0;
      repeat (60) pending_pairs.push_back(random_pair());
      recv_hold = 1;
      repeat (300) @(posedge clock);
      recv_hold = 0;
      wait_drained();

      // random, swapped idling mix
      send_idle_pct = 53;
      recv_idle_pct = 14;
      repeat (320) pending_pairs.push_back(random_pair());
      wait_drained();

      // random, no idling
      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (320) pending_pairs.push_back(random_pair());
      wait_drained();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && expected_contacts.size() == 0)
         $display("circle_circle_contact_tb passed");
      else
         $display("circle_circle_contact_tb failed");
      $finish;
   end

endmodule
